/* rtl/core/mbrtu_pkg.sv */
// shared constants and types for the modbus rtu response parser
package mbrtu_pkg;

   // parse states
   localparam logic [2:0] PS_ADDR   = 3'd0;
   localparam logic [2:0] PS_FUNC   = 3'd1;
   localparam logic [2:0] PS_EXC    = 3'd2;
   localparam logic [2:0] PS_COUNT  = 3'd3;
   localparam logic [2:0] PS_DATA   = 3'd4;
   localparam logic [2:0] PS_REG    = 3'd5;
   localparam logic [2:0] PS_REGLEN = 3'd6;
   localparam logic [2:0] PS_CRC    = 3'd7;

   // function codes and crc constants
   localparam logic [7:0]  FN_READ  = 8'h03;
   localparam logic [7:0]  FN_WRITE = 8'h10;
   localparam logic [7:0]  FN_EXC   = 8'h80;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   // request opcodes
   localparam logic OP_RX   = 1'b0;
   localparam logic OP_READ = 1'b1;

   // result kinds
   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_EXC   = 2'd2;

   // sequencer phases
   typedef enum logic [2:0] {
      SQ_IDLE, SQ_FETCH, SQ_WAIT, SQ_EVAL, SQ_CRC, SQ_FNWAIT, SQ_FNEVAL, SQ_CLEAR
   } seq_type;

   // one bit step of the modbus crc
   function automatic logic [15:0] crc_bit(input logic [15:0] crc);
      crc_bit = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
   endfunction

endpackage

/* rtl/core/mbrtu_ram.sv */
// generic single port write, single port registered read ram
module mbrtu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

/* rtl/core/modbus_rtu_response_parser.sv */
// modbus rtu response parser top level with byte sequencer and shared crc unit
//
//  channel  direction  ports
//  req      in         req_valid req_stall req_opcode req_rx_byte req_data_index
//  rsp      out        rsp_valid rsp_stall rsp_frame_done .. rsp_read_data
//  csr      in         csr_wr_en csr_wr_data (expected slave address)
//
// a stored read passes through the wait state, which registers the store data into
// the result. a received byte is written to the window, then each buffered byte
// scanned is fetched and evaluated and, when it is folded into the crc, passes through
// the shared shift unit, one crc bit each cycle; an accepted frame then fetches its
// function code in the fnwait and fneval states. a rejected frame rescans from one
// byte after its start. accepting a byte count clears all the data store valid flags
// together. reset is synchronous; no clearing pass after it. the next request is
// taken once the result register is free and the sequencer is idle.
module modbus_rtu_response_parser #(
   parameter int BUFFER_DEPTH  = 512,
   parameter int MAX_READ_REGS = 125
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_opcode,
   input  logic [7:0] req_rx_byte,
   input  logic [7:0] req_data_index,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_frame_done,
   output logic [1:0] rsp_frame_kind,
   output logic [7:0] rsp_exception_code,
   output logic [7:0] rsp_data_count,
   output logic       rsp_byte_dropped,
   output logic [7:0] rsp_read_data,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);
   import mbrtu_pkg::*;

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int PW = AW + 1;
   localparam int STORE_DEPTH = 2 * MAX_READ_REGS;
   localparam int SW = $clog2(STORE_DEPTH);
   localparam logic [PW-1:0] PTR_LAST = PW'(2 * BUFFER_DEPTH - 1);

   // registers
   logic [7:0]    slave_ff;
   seq_type       seq_ff, seq_in;
   logic [PW-1:0] wptr_ff, wptr_in, fptr_ff, fptr_in, sptr_ff, sptr_in;
   logic [2:0]    ps_ff, ps_in;
   logic [15:0]   crc_ff, crc_in;
   logic [7:0]    crclo_ff, crclo_in, fidx_ff, fidx_in, flen_ff, flen_in;
   logic [7:0]    pexc_ff, pexc_in, dlen_ff, dlen_in, byte_ff, byte_in;
   logic [2:0]    bit_ff, bit_in;
   logic          rd_oor_ff, rd_oor_in;
   logic          ov_ff, ov_in, done_ff, done_in, drop_ff, drop_in;
   logic [1:0]    kind_ff, kind_in;
   logic [7:0]    exc_ff, exc_in, rdata_ff, rdata_in;
   logic [STORE_DEPTH-1:0] sval_ff, sval_in;

   // ram ports
   logic          wb_we;
   logic [AW-1:0] wb_wa, wb_ra;
   logic [7:0]    wb_rd;
   logic          ds_we;
   logic [SW-1:0] ds_wa, ds_ra;
   logic [7:0]    ds_wd, ds_rd;

   logic [PW-1:0] fill;
   logic [PW-1:0] fnptr;
   logic          accept;

   function automatic logic [PW-1:0] pinc(input logic [PW-1:0] p);
      pinc = (p == PTR_LAST) ? '0 : p + PW'(1);
   endfunction

   mbrtu_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_window (
      .clock(clock), .wr_en(wb_we), .wr_addr(wb_wa), .wr_data(req_rx_byte),
      .rd_addr(wb_ra), .rd_data(wb_rd));

   mbrtu_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
      .clock(clock), .wr_en(ds_we), .wr_addr(ds_wa), .wr_data(ds_wd),
      .rd_addr(ds_ra), .rd_data(ds_rd));

   assign req_stall = (seq_ff != SQ_IDLE) || ov_ff;
   assign accept = req_valid && !req_stall;
   assign fill = (wptr_ff >= fptr_ff) ? wptr_ff - fptr_ff
                                      : wptr_ff + PW'(2 * BUFFER_DEPTH) - fptr_ff;
   // address of the function byte of the current frame
   assign fnptr = pinc(fptr_ff);

   // sequencer and parser
   always_comb begin
      seq_in = seq_ff; wptr_in = wptr_ff; fptr_in = fptr_ff; sptr_in = sptr_ff;
      ps_in = ps_ff; crc_in = crc_ff; crclo_in = crclo_ff; fidx_in = fidx_ff;
      flen_in = flen_ff; pexc_in = pexc_ff; dlen_in = dlen_ff; byte_in = byte_ff;
      bit_in = bit_ff; rd_oor_in = rd_oor_ff; rdata_in = rdata_ff;
      ov_in = ov_ff; done_in = done_ff; drop_in = drop_ff; kind_in = kind_ff;
      exc_in = exc_ff; sval_in = sval_ff;
      wb_we = 1'b0; wb_wa = wptr_ff[AW-1:0]; wb_ra = sptr_ff[AW-1:0];
      ds_we = 1'b0; ds_wa = fidx_ff[SW-1:0]; ds_wd = byte_ff;
      ds_ra = req_data_index[SW-1:0];
      if (ov_ff && !rsp_stall) begin
         ov_in = 1'b0;
      end
      case (seq_ff)
         SQ_IDLE: begin
            if (accept) begin
               done_in = 1'b0; kind_in = KIND_READ; exc_in = '0; drop_in = 1'b0;
               rdata_in = '0;
               rd_oor_in = (req_data_index >= 8'(STORE_DEPTH)) ||
                  !sval_ff[req_data_index[SW-1:0]];
               if (req_opcode == OP_READ) begin
                  seq_in = SQ_WAIT; ps_in = ps_ff;
               end else if (fill >= PW'(BUFFER_DEPTH)) begin
                  drop_in = 1'b1; ov_in = 1'b1;
               end else begin
                  wb_we = 1'b1;
                  wptr_in = pinc(wptr_ff);
                  seq_in = SQ_FETCH;
               end
            end
         end
         SQ_FETCH: begin
            // issue read of next scanned byte or finish
            if (sptr_ff == wptr_ff) begin
               seq_in = SQ_IDLE; ov_in = 1'b1;
            end else begin
               sptr_in = pinc(sptr_ff);
               seq_in = SQ_EVAL;
            end
         end
         SQ_WAIT: begin
            // stored read data registered, hold it for the result
            rdata_in = rd_oor_ff ? 8'h00 : ds_rd;
            seq_in = SQ_IDLE; ov_in = 1'b1;
         end
         SQ_EVAL: begin
            byte_in = wb_rd;
            seq_in = SQ_FETCH;
            case (ps_ff)
               PS_ADDR: begin
                  if (wb_rd == slave_ff) begin
                     ps_in = PS_FUNC; crc_in = CRC_INIT ^ {8'h00, wb_rd};
                     bit_in = '0; seq_in = SQ_CRC;
                  end else begin
                     ps_in = PS_ADDR; pexc_in = '0; fptr_in = pinc(fptr_ff);
                     sptr_in = pinc(fptr_ff);
                  end
               end
               PS_FUNC: begin
                  if (wb_rd == FN_READ || wb_rd == FN_WRITE || (wb_rd & FN_EXC) != 0) begin
                     ps_in = (wb_rd == FN_READ) ? PS_COUNT :
                             (wb_rd == FN_WRITE) ? PS_REG : PS_EXC;
                     fidx_in = '0; flen_in = 8'd2;
                     crc_in = crc_ff ^ {8'h00, wb_rd}; bit_in = '0; seq_in = SQ_CRC;
                  end else begin
                     ps_in = PS_ADDR; pexc_in = '0; fptr_in = pinc(fptr_ff);
                     sptr_in = pinc(fptr_ff);
                  end
               end
               PS_EXC: begin
                  pexc_in = wb_rd; fidx_in = '0; flen_in = 8'd2; ps_in = PS_CRC;
                  crc_in = crc_ff ^ {8'h00, wb_rd}; bit_in = '0; seq_in = SQ_CRC;
               end
               PS_COUNT: begin
                  if (wb_rd > 8'(STORE_DEPTH)) begin
                     ps_in = PS_ADDR; pexc_in = '0; fptr_in = pinc(fptr_ff);
                     sptr_in = pinc(fptr_ff);
                  end else begin
                     fidx_in = '0; flen_in = wb_rd; ps_in = PS_DATA;
                     crc_in = crc_ff ^ {8'h00, wb_rd}; bit_in = '0;
                     sval_in = '0; seq_in = SQ_CRC;
                  end
               end
               PS_DATA: begin
                  if (fidx_ff < 8'(STORE_DEPTH)) begin
                     ds_we = 1'b1; ds_wd = wb_rd;
                     sval_in[fidx_ff[SW-1:0]] = 1'b1;
                  end
                  fidx_in = fidx_ff + 8'd1;
                  crc_in = crc_ff ^ {8'h00, wb_rd}; bit_in = '0; seq_in = SQ_CRC;
                  if ((fidx_ff + 8'd1) >= flen_ff) begin
                     dlen_in = fidx_ff + 8'd1; fidx_in = '0; flen_in = 8'd2;
                     ps_in = PS_CRC;
                  end
               end
               PS_REG, PS_REGLEN: begin
                  fidx_in = fidx_ff + 8'd1;
                  crc_in = crc_ff ^ {8'h00, wb_rd}; bit_in = '0; seq_in = SQ_CRC;
                  if ((fidx_ff + 8'd1) >= flen_ff) begin
                     fidx_in = '0; flen_in = 8'd2;
                     ps_in = (ps_ff == PS_REG) ? PS_REGLEN : PS_CRC;
                  end
               end
               default: begin
                  if (fidx_ff == 8'd0) begin
                     crclo_in = wb_rd; fidx_in = 8'd1;
                  end else begin
                     fidx_in = '0;
                     if ({wb_rd, crclo_ff} == crc_ff) begin
                        wb_ra = fnptr[AW-1:0];
                        seq_in = SQ_FNWAIT;
                     end else begin
                        ps_in = PS_ADDR; pexc_in = '0; fptr_in = pinc(fptr_ff);
                        sptr_in = pinc(fptr_ff);
                     end
                  end
               end
            endcase
         end
         SQ_CRC: begin
            // shared crc shift unit, one bit a cycle
            crc_in = crc_bit(crc_ff);
            bit_in = bit_ff + 3'd1;
            if (bit_ff == 3'd7) begin
               seq_in = SQ_FETCH;
            end
         end
         SQ_FNWAIT: begin
            wb_ra = fnptr[AW-1:0];
            seq_in = SQ_FNEVAL;
         end
         SQ_FNEVAL: begin
            done_in = 1'b1;
            kind_in = (wb_rd == FN_READ) ? KIND_READ :
                      (wb_rd == FN_WRITE) ? KIND_WRITE : KIND_EXC;
            exc_in = (wb_rd == FN_READ || wb_rd == FN_WRITE) ? 8'h00 : pexc_ff;
            pexc_in = '0; ps_in = PS_ADDR; fptr_in = sptr_ff;
            seq_in = SQ_IDLE; ov_in = 1'b1;
         end
         default: begin
            seq_in = SQ_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= SQ_IDLE; slave_ff <= 8'd1; wptr_ff <= '0; fptr_ff <= '0;
         sptr_ff <= '0; ps_ff <= PS_ADDR; crc_ff <= CRC_INIT; crclo_ff <= '0;
         fidx_ff <= '0; flen_ff <= '0; pexc_ff <= '0; dlen_ff <= '0;
         sval_ff <= '0; ov_ff <= 1'b0;
      end else begin
         seq_ff <= seq_in; wptr_ff <= wptr_in; fptr_ff <= fptr_in;
         sptr_ff <= sptr_in; ps_ff <= ps_in; crc_ff <= crc_in; crclo_ff <= crclo_in;
         fidx_ff <= fidx_in; flen_ff <= flen_in; pexc_ff <= pexc_in;
         dlen_ff <= dlen_in; sval_ff <= sval_in; ov_ff <= ov_in;
         if (csr_wr_en) begin
            slave_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      byte_ff <= byte_in; bit_ff <= bit_in;
      rd_oor_ff <= rd_oor_in; rdata_ff <= rdata_in; done_ff <= done_in;
      drop_ff <= drop_in; kind_ff <= kind_in; exc_ff <= exc_in;
   end

   // result
   assign rsp_valid          = ov_ff;
   assign rsp_frame_done     = done_ff;
   assign rsp_frame_kind     = kind_ff;
   assign rsp_exception_code = exc_ff;
   assign rsp_data_count     = dlen_ff;
   assign rsp_byte_dropped   = drop_ff;
   assign rsp_read_data      = rdata_ff;

   // checks
   a_no_take_busy: assert property (@(posedge clock) disable iff (reset)
      (seq_ff != SQ_IDLE) |-> req_stall) else $error("request taken while busy");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill <= PW'(BUFFER_DEPTH)) else $error("window overfilled");
   a_done_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_frame_done) |-> (rsp_frame_kind == KIND_READ))
      else $error("kind without frame");
   a_drop_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_byte_dropped && rsp_frame_done)) else $error("drop and done");
endmodule
